@@ design/slids_pkg.sv @@
// types, codes and result packing shared by the list core and its cells
`default_nettype none

package slids_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_SORT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROT,
    S_SORT,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_WRITE,
    CM_ROTATE,
    CM_SORT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       wr_en;
    logic       phase;
  } cell_ctl_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] entry_value;
    logic [3:0]         entry_position;
    logic [4:0]         entries_held;
    logic               last;
  } res_t;

  function automatic res_t make_res(status_t st, logic signed [31:0] v, logic [3:0] pos,
                                    logic [4:0] held, logic lst);
    res_t r;
    r.status         = st;
    r.entry_value    = v;
    r.entry_position = pos;
    r.entries_held   = held;
    r.last           = lst;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/slids_if.sv @@
// request and result channel interfaces
`default_nettype none

interface slids_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface slids_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] entry_value;
  logic [3:0]         entry_position;
  logic [4:0]         entries_held;
  logic               last;

  modport source (output valid, output status, output entry_value, output entry_position,
                  output entries_held, output last, input ready);
  modport sink (input valid, input status, input entry_value, input entry_position,
                input entries_held, input last, output ready);
endinterface

`default_nettype wire

@@ design/small_list_insert_delete_sort_core.sv @@
// list core: control sequencer over a chain of entry cells
//
//   channel   dir  handshake        payload
//   in_if     in   valid / ready    op, value
//   out_if    out  valid / ready    status, entry_value, entry_position,
//                                   entries_held, last
//
// insert, and any request on an empty list (sort also on one entry), take 1 cycle.
// read: 1 cycle to take the request, then one rotation per result, each held off while
// the output register is full; delete: 1 cycle, count rotations dropping the first match,
// then 1 cycle for the result; sort: 1 cycle, count odd-even passes, then 1 cycle.
// rst_n is synchronous, clears the entry count and the control; cell contents are not reset.
// a new request is taken only in idle with the output register free or draining.
`default_nettype none

module small_list_insert_delete_sort_core #(
  parameter int CAPACITY = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  slids_in_if.sink  in_if,
  slids_out_if.source out_if
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  slids_pkg::state_t   state_r, state_nxt;
  slids_pkg::op_t      op_r, op_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    end_r, end_nxt;
  logic [CNT_W-1:0]    step_r, step_nxt;
  logic                found_r, found_nxt;
  logic signed [31:0]  key_r, key_nxt;
  logic                ov_r, ov_nxt;
  slids_pkg::res_t     res_r, res_nxt;

  slids_pkg::cell_ctl_t ctl;
  logic [IDX_W-1:0]     wr_idx;
  logic signed [31:0]   wdata;
  logic signed [31:0]   cell_val [CAPACITY];
  logic                 cell_gt  [CAPACITY];
  logic signed [31:0]   head;
  logic                 out_free;
  logic                 accept;
  logic                 step_last;

  assign head      = cell_val[0];
  assign out_free  = !ov_r || out_if.ready;
  assign in_if.ready = (state_r == slids_pkg::S_IDLE) && out_free;
  assign accept    = in_if.valid && in_if.ready;
  assign step_last = (step_r == end_r - CNT_W'(1));

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [31:0] nv;
      logic signed [31:0] pv;
      logic               pg;
      if (g == CAPACITY - 1) begin : g_tail
        assign nv = cell_val[g];
      end else begin : g_mid
        assign nv = cell_val[g+1];
      end
      if (g == 0) begin : g_head
        assign pv = '0;
        assign pg = 1'b0;
      end else begin : g_rest
        assign pv = cell_val[g-1];
        assign pg = cell_gt[g-1];
      end
      slids_cell #(
        .IDX   (g),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .wr_idx   (wr_idx),
        .len      (count_r),
        .wdata    (wdata),
        .next_val (nv),
        .prev_val (pv),
        .prev_gt  (pg),
        .val      (cell_val[g]),
        .val_gt   (cell_gt[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    count_nxt = count_r;
    end_nxt   = end_r;
    step_nxt  = step_r;
    found_nxt = found_r;
    key_nxt   = key_r;
    ov_nxt    = ov_r && !out_if.ready;
    res_nxt   = res_r;
    ctl.mode  = slids_pkg::CM_HOLD;
    ctl.wr_en = 1'b0;
    ctl.phase = step_r[0];
    wr_idx    = IDX_W'(count_r - CNT_W'(1));
    wdata     = head;

    unique case (state_r)
      slids_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt    = slids_pkg::op_t'(in_if.op);
          key_nxt   = in_if.value;
          step_nxt  = '0;
          end_nxt   = count_r;
          found_nxt = 1'b0;
          unique case (slids_pkg::op_t'(in_if.op))
            slids_pkg::OP_INSERT: begin
              ov_nxt = 1'b1;
              if (count_r < CNT_W'(CAPACITY)) begin
                ctl.mode  = slids_pkg::CM_WRITE;
                wr_idx    = IDX_W'(count_r);
                wdata     = in_if.value;
                count_nxt = count_r + CNT_W'(1);
                res_nxt   = slids_pkg::make_res(slids_pkg::ST_DONE, '0, '0,
                                                5'(count_r + CNT_W'(1)), 1'b1);
              end else begin
                res_nxt   = slids_pkg::make_res(slids_pkg::ST_FULL, '0, '0,
                                                5'(count_r), 1'b1);
              end
            end
            slids_pkg::OP_DELETE: begin
              if (count_r == '0) begin
                ov_nxt  = 1'b1;
                res_nxt = slids_pkg::make_res(slids_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1);
              end else begin
                state_nxt = slids_pkg::S_ROT;
              end
            end
            slids_pkg::OP_READ: begin
              if (count_r == '0) begin
                ov_nxt  = 1'b1;
                res_nxt = slids_pkg::make_res(slids_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
              end else begin
                state_nxt = slids_pkg::S_ROT;
              end
            end
            slids_pkg::OP_SORT: begin
              if (count_r < CNT_W'(2)) begin
                ov_nxt  = 1'b1;
                res_nxt = slids_pkg::make_res(slids_pkg::ST_DONE, '0, '0,
                                              5'(count_r), 1'b1);
              end else begin
                state_nxt = slids_pkg::S_SORT;
              end
            end
            default: state_nxt = slids_pkg::S_IDLE;
          endcase
        end
      end

      slids_pkg::S_ROT: begin
        if (op_r == slids_pkg::OP_READ) begin
          // head leaves with its result and re-enters at the tail
          if (out_free) begin
            ctl.mode  = slids_pkg::CM_ROTATE;
            ctl.wr_en = 1'b1;
            ov_nxt    = 1'b1;
            res_nxt   = slids_pkg::make_res(slids_pkg::ST_DONE, head, 4'(step_r),
                                            5'(count_r), step_last);
            step_nxt  = step_r + CNT_W'(1);
            if (step_last) state_nxt = slids_pkg::S_IDLE;
          end
        end else begin
          // first match at the head is dropped, everything else goes to the tail
          ctl.mode = slids_pkg::CM_ROTATE;
          if (head == key_r && !found_r) begin
            ctl.wr_en = 1'b0;
            count_nxt = count_r - CNT_W'(1);
            found_nxt = 1'b1;
          end else begin
            ctl.wr_en = 1'b1;
          end
          step_nxt = step_r + CNT_W'(1);
          if (step_last) state_nxt = slids_pkg::S_FIN;
        end
      end

      slids_pkg::S_SORT: begin
        ctl.mode = slids_pkg::CM_SORT;
        step_nxt = step_r + CNT_W'(1);
        if (step_last) state_nxt = slids_pkg::S_FIN;
      end

      slids_pkg::S_FIN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          res_nxt   = slids_pkg::make_res(
                        (op_r == slids_pkg::OP_DELETE && !found_r) ?
                          slids_pkg::ST_NOT_FOUND : slids_pkg::ST_DONE,
                        '0, '0, 5'(count_r), 1'b1);
          state_nxt = slids_pkg::S_IDLE;
        end
      end

      default: state_nxt = slids_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slids_pkg::S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
      step_r  <= '0;
      end_r   <= '0;
      found_r <= 1'b0;
      op_r    <= slids_pkg::OP_INSERT;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
      step_r  <= step_nxt;
      end_r   <= end_nxt;
      found_r <= found_nxt;
      op_r    <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  assign out_if.valid          = ov_r;
  assign out_if.status         = res_r.status;
  assign out_if.entry_value    = res_r.entry_value;
  assign out_if.entry_position = res_r.entry_position;
  assign out_if.entries_held   = res_r.entries_held;
  assign out_if.last           = res_r.last;

endmodule

`default_nettype wire

@@ design/slids_cell.sv @@
// one list entry: append write, rotate toward head, odd-even compare-exchange
`default_nettype none

module slids_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  wire logic               clk,
  input  wire slids_pkg::cell_ctl_t ctl,
  input  wire logic [IDX_W-1:0]   wr_idx,
  input  wire logic [CNT_W-1:0]   len,
  input  wire logic signed [31:0] wdata,
  input  wire logic signed [31:0] next_val,
  input  wire logic signed [31:0] prev_val,
  input  wire logic               prev_gt,
  output logic signed [31:0]      val,
  output logic                    val_gt
);

  localparam logic PAR = 1'(IDX % 2);

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;
  logic               hit;
  logic               lower;
  logic               upper;

  assign hit    = (IDX_W'(IDX) == wr_idx);
  assign val_gt = (val_r > next_val);
  // lower member of a pair keeps the min, upper member takes the max
  assign lower  = (PAR == ctl.phase) && (CNT_W'(IDX + 1) < len);
  assign upper  = (PAR != ctl.phase) && (IDX >= 1) && (CNT_W'(IDX) < len);

  always_comb begin
    val_nxt = val_r;
    unique case (ctl.mode)
      slids_pkg::CM_HOLD: begin
        val_nxt = val_r;
      end
      slids_pkg::CM_WRITE: begin
        if (hit) val_nxt = wdata;
      end
      slids_pkg::CM_ROTATE: begin
        val_nxt = (ctl.wr_en && hit) ? wdata : next_val;
      end
      slids_pkg::CM_SORT: begin
        if (lower && val_gt) begin
          val_nxt = next_val;
        end else if (upper && prev_gt) begin
          val_nxt = prev_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

@@ tb/small_list_insert_delete_sort_core_tb.sv @@
// testbench for the list core: directed and random requests checked against a list model
`timescale 1ns / 1ps

module small_list_insert_delete_sort_core_tb;

  localparam int CAPACITY = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst_n;

  slids_in_if in_if ();
  slids_out_if out_if ();

  small_list_insert_delete_sort_core #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_if),
    .out_if(out_if)
  );

  // list model and the results it still owes
  logic signed [31:0] model_entries[CAPACITY];
  int                 model_count;
  slids_pkg::res_t    pending_results[$];

  int mismatch_count;
  int cycle_count;
  int burst_left;
  int stall_mode;
  int stall_window;
  int stall_tick;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // apply one request to the model and queue the results it produces
  function automatic void model_list_op(slids_pkg::op_t op, logic signed [31:0] value);
    logic signed [31:0] key;
    int                 hit;
    int                 j;
    hit = -1;
    case (op)
      slids_pkg::OP_INSERT: begin
        if (model_count < CAPACITY) begin
          model_entries[model_count] = value;
          model_count++;
          pending_results.push_back(slids_pkg::make_res(slids_pkg::ST_DONE, 0, 4'd0,
                                                        model_count[4:0], 1'b1));
        end else begin
          pending_results.push_back(slids_pkg::make_res(slids_pkg::ST_FULL, 0, 4'd0,
                                                        model_count[4:0], 1'b1));
        end
      end
      slids_pkg::OP_DELETE: begin
        for (int i = 0; i < model_count; i++) begin
          if (hit < 0 && model_entries[i] == value) hit = i;
        end
        if (hit >= 0) begin
          for (int i = hit; i + 1 < model_count; i++) model_entries[i] = model_entries[i + 1];
          model_count--;
          pending_results.push_back(slids_pkg::make_res(slids_pkg::ST_DONE, 0, 4'd0,
                                                        model_count[4:0], 1'b1));
        end else begin
          pending_results.push_back(slids_pkg::make_res(slids_pkg::ST_NOT_FOUND, 0, 4'd0,
                                                        model_count[4:0], 1'b1));
        end
      end
      slids_pkg::OP_READ: begin
        if (model_count == 0) begin
          pending_results.push_back(slids_pkg::make_res(slids_pkg::ST_EMPTY, 0, 4'd0,
                                                        5'd0, 1'b1));
        end else begin
          for (int i = 0; i < model_count; i++) begin
            pending_results.push_back(slids_pkg::make_res(slids_pkg::ST_DONE,
                                                          model_entries[i], i[3:0],
                                                          model_count[4:0],
                                                          i + 1 == model_count));
          end
        end
      end
      default: begin
        // insertion sort, signed ascending
        for (int i = 1; i < model_count; i++) begin
          key = model_entries[i];
          j = i - 1;
          while (j >= 0 && model_entries[j] > key) begin
            model_entries[j + 1] = model_entries[j];
            j--;
          end
          model_entries[j + 1] = key;
        end
        pending_results.push_back(slids_pkg::make_res(slids_pkg::ST_DONE, 0, 4'd0,
                                                      model_count[4:0], 1'b1));
      end
    endcase
  endfunction

  // one request on the input channel, with bursty gaps in front of it
  task automatic send_request(slids_pkg::op_t op, logic signed [31:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.op    <= op;
    in_if.value <= value;
    do @(posedge clk); while (!in_if.ready);
    model_list_op(op, value);
  endtask

  task automatic await_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2, 3, 4: return $urandom_range(0, 16) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] delete_target();
    if (model_count > 0 && $urandom_range(0, 9) < 7) begin
      return model_entries[$urandom_range(0, model_count - 1)];
    end
    return random_value();
  endfunction

  task automatic test_empty_list();
    send_request(slids_pkg::OP_READ, 0);
    send_request(slids_pkg::OP_SORT, VAL_MAX);
    send_request(slids_pkg::OP_DELETE, 0);
  endtask

  task automatic test_extremes();
    send_request(slids_pkg::OP_INSERT, VAL_MIN);
    send_request(slids_pkg::OP_INSERT, VAL_MAX);
    send_request(slids_pkg::OP_INSERT, -1);
    send_request(slids_pkg::OP_INSERT, 0);
    send_request(slids_pkg::OP_SORT, 0);
    send_request(slids_pkg::OP_READ, 0);
    send_request(slids_pkg::OP_DELETE, VAL_MAX);
    send_request(slids_pkg::OP_DELETE, 5);
    send_request(slids_pkg::OP_DELETE, VAL_MIN);
    send_request(slids_pkg::OP_DELETE, 0);
    // sort of a single entry
    send_request(slids_pkg::OP_SORT, 0);
    send_request(slids_pkg::OP_READ, 0);
  endtask

  task automatic test_full_list();
    while (model_count < CAPACITY) begin
      send_request(slids_pkg::OP_INSERT, ($urandom_range(0, 2) == 0) ? random_value()
                                                                    : $urandom_range(0, 6) - 3);
    end
    send_request(slids_pkg::OP_INSERT, 99);
    send_request(slids_pkg::OP_SORT, 0);
    send_request(slids_pkg::OP_READ, 0);
    // duplicates are likely, so this removes only the first match
    send_request(slids_pkg::OP_DELETE, model_entries[CAPACITY / 2]);
    send_request(slids_pkg::OP_READ, 0);
  endtask

  task automatic test_random_traffic(int count, int insert_pct, int delete_pct, int read_pct);
    int              roll;
    slids_pkg::op_t  op;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < insert_pct) op = slids_pkg::OP_INSERT;
      else if (roll < insert_pct + delete_pct) op = slids_pkg::OP_DELETE;
      else if (roll < insert_pct + delete_pct + read_pct) op = slids_pkg::OP_READ;
      else op = slids_pkg::OP_SORT;
      send_request(op, (op == slids_pkg::OP_DELETE) ? delete_target() : random_value());
    end
  endtask

  // receiver stalls: always ready, mostly ready, one in four, or long stalls
  initial begin
    out_if.ready = 1'b0;
    stall_window = 0;
    stall_tick = 0;
    forever begin
      @(posedge clk);
      if (stall_window == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_window = $urandom_range(16, 96);
      end
      stall_window--;
      stall_tick++;
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= (stall_tick % 4 == 0);
        default: out_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    slids_pkg::res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) $display("result with no request pending: status %0d",
                                          out_if.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status || out_if.entry_value !== want.entry_value ||
            out_if.entry_position !== want.entry_position ||
            out_if.entries_held !== want.entries_held || out_if.last !== want.last) begin
          if (mismatch_count < 10) begin
            $display("mismatch (exp/act): status %0d/%0d value %0d/%0d pos %0d/%0d",
                     want.status, out_if.status, want.entry_value, out_if.entry_value,
                     want.entry_position, out_if.entry_position);
            $display("  held %0d/%0d last %0d/%0d", want.entries_held, out_if.entries_held,
                     want.last, out_if.last);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("small_list_insert_delete_sort_core regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = slids_pkg::OP_INSERT;
    in_if.value = '0;
    model_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_extremes();
    test_full_list();
    await_drain();
    test_random_traffic(100, 60, 15, 15);
    await_drain();
    test_random_traffic(100, 15, 60, 15);
    test_random_traffic(100, 35, 30, 20);

    await_drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("small_list_insert_delete_sort_core regression: pass");
    end else begin
      $display("small_list_insert_delete_sort_core regression: fail");
    end
    $finish;
  end

endmodule
